// ----- design/hsvr_pkg.sv -----
// Package for the rainbow HSV to RGB converter: field types, hue segment
// codes, level constants and the 8-bit scaling helpers. No dependencies.
`timescale 1ns / 1ps

package hsvr_pkg;

  // Hue wheel segments picked by hue bits 7:5
  typedef enum logic [2:0] {
    SegRedOrange    = 3'd0,
    SegOrangeYellow = 3'd1,
    SegYellowGreen  = 3'd2,
    SegGreenAqua    = 3'd3,
    SegAquaBlue     = 3'd4,
    SegBluePurple   = 3'd5,
    SegPurplePink   = 3'd6,
    SegPinkRed      = 3'd7
  } hue_seg_e;

  localparam logic [7:0] LvlFull = 8'd255;
  localparam logic [7:0] LvlHi   = 8'd171;
  localparam logic [7:0] LvlMid  = 8'd170;
  localparam logic [7:0] LvlLo   = 8'd85;

  // Scale factors plus one, as the multiplier sees them
  localparam logic [8:0] OneThirdP1  = 9'((256 / 3) + 1);
  localparam logic [8:0] TwoThirdsP1 = 9'(((256 * 2) / 3) + 1);

  // (a * (b + 1)) >> 8, with b + 1 already formed
  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [8:0] bp1);
    logic [16:0] prod;
    prod = {9'b0, a} * {8'b0, bp1};
    return prod[15:8];
  endfunction

  // ((a * a) >> 8) + (a != 0)
  function automatic logic [7:0] square_video(input logic [7:0] a);
    logic [15:0] prod;
    prod = {8'b0, a} * {8'b0, a};
    return prod[15:8] + {7'b0, (a != 8'd0)};
  endfunction

  typedef struct packed {
    hue_seg_e   seg;
    logic [7:0] t1;
    logic [7:0] t2;
    logic [7:0] d;
    logic [7:0] v;
    logic       sat_full;
    logic       sat_zero;
    logic       val_full;
    logic       val_zero;
  } s1_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] d;
    logic [8:0] sp1;
    logic [7:0] v;
    logic       sat_full;
    logic       sat_zero;
    logic       val_full;
    logic       val_zero;
  } s2_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] v;
    logic       val_full;
    logic       val_zero;
  } s3_t;

endpackage

// ----- design/hsvr_hsv_if.sv -----
// Input channel of the converter: one HSV pixel per beat.
// Standalone; valid/ready handshake with source and sink modports.
`timescale 1ns / 1ps

interface hsvr_hsv_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] sat;
  logic [7:0] val;

  modport source (output valid, output hue, output sat, output val, input ready);
  modport sink   (input valid, input hue, input sat, input val, output ready);
endinterface

// ----- design/hsvr_rgb_if.sv -----
// Output channel of the converter: one RGB pixel per beat.
// Standalone; valid/ready handshake with source and sink modports.
`timescale 1ns / 1ps

interface hsvr_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- design/hsv_rainbow_to_rgb.sv -----
// Throughput: 1 pixel per cycle while the output takes beats; four
// register stages (hue thirds and squares, segment select, desaturation,
// value scale). A stall at the output backs up only through full stages.
// Reset: asynchronous active-low reset empties all stages; payload is not reset.
// Depends on hsvr_pkg, hsvr_hsv_if and hsvr_rgb_if.
`timescale 1ns / 1ps

module hsv_rainbow_to_rgb (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsvr_hsv_if.sink    hsv_i,
  hsvr_rgb_if.source  rgb_o
);

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic en1, en2, en3, en4;

  hsvr_pkg::s1_t s1_d, s1_q;
  hsvr_pkg::s2_t s2_d, s2_q;
  hsvr_pkg::s3_t s3_d, s3_q;
  logic [7:0] red_d, green_d, blue_d;
  logic [7:0] red_q, green_q, blue_q;

  // A stage loads when it is empty or its contents move on
  assign en4 = !s4_valid_q || rgb_o.ready;
  assign en3 = !s3_valid_q || en4;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;

  assign hsv_i.ready = en1;
  assign rgb_o.valid = s4_valid_q;
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

  // Stage 1: hue thirds and the two squared curves
  always_comb begin
    logic [7:0] ofs;
    ofs            = {hsv_i.hue[4:0], 3'b000};
    s1_d.seg       = hsvr_pkg::hue_seg_e'(hsv_i.hue[7:5]);
    s1_d.t1        = hsvr_pkg::scale8(ofs, hsvr_pkg::OneThirdP1);
    s1_d.t2        = hsvr_pkg::scale8(ofs, hsvr_pkg::TwoThirdsP1);
    s1_d.d         = hsvr_pkg::square_video(hsvr_pkg::LvlFull - hsv_i.sat);
    s1_d.v         = hsvr_pkg::square_video(hsv_i.val);
    s1_d.sat_full  = (hsv_i.sat == hsvr_pkg::LvlFull);
    s1_d.sat_zero  = (hsv_i.sat == 8'd0);
    s1_d.val_full  = (hsv_i.val == hsvr_pkg::LvlFull);
    s1_d.val_zero  = (hsv_i.val == 8'd0);
  end

  // Stage 2: rainbow segment select
  always_comb begin
    s2_d.d        = s1_q.d;
    s2_d.sp1      = 9'd256 - {1'b0, s1_q.d};
    s2_d.v        = s1_q.v;
    s2_d.sat_full = s1_q.sat_full;
    s2_d.sat_zero = s1_q.sat_zero;
    s2_d.val_full = s1_q.val_full;
    s2_d.val_zero = s1_q.val_zero;
    case (s1_q.seg)
      hsvr_pkg::SegRedOrange: begin
        s2_d.r = hsvr_pkg::LvlFull - s1_q.t1;
        s2_d.g = s1_q.t1;
        s2_d.b = 8'd0;
      end
      hsvr_pkg::SegOrangeYellow: begin
        s2_d.r = hsvr_pkg::LvlHi;
        s2_d.g = hsvr_pkg::LvlLo + s1_q.t1;
        s2_d.b = 8'd0;
      end
      hsvr_pkg::SegYellowGreen: begin
        s2_d.r = hsvr_pkg::LvlHi - s1_q.t2;
        s2_d.g = hsvr_pkg::LvlMid + s1_q.t1;
        s2_d.b = 8'd0;
      end
      hsvr_pkg::SegGreenAqua: begin
        s2_d.r = 8'd0;
        s2_d.g = hsvr_pkg::LvlFull - s1_q.t1;
        s2_d.b = s1_q.t1;
      end
      hsvr_pkg::SegAquaBlue: begin
        s2_d.r = 8'd0;
        s2_d.g = hsvr_pkg::LvlHi - s1_q.t2;
        s2_d.b = hsvr_pkg::LvlLo + s1_q.t2;
      end
      hsvr_pkg::SegBluePurple: begin
        s2_d.r = s1_q.t1;
        s2_d.g = 8'd0;
        s2_d.b = hsvr_pkg::LvlFull - s1_q.t1;
      end
      hsvr_pkg::SegPurplePink: begin
        s2_d.r = hsvr_pkg::LvlLo + s1_q.t1;
        s2_d.g = 8'd0;
        s2_d.b = hsvr_pkg::LvlHi - s1_q.t1;
      end
      hsvr_pkg::SegPinkRed: begin
        s2_d.r = hsvr_pkg::LvlMid + s1_q.t1;
        s2_d.g = 8'd0;
        s2_d.b = hsvr_pkg::LvlLo - s1_q.t1;
      end
      default: begin
        s2_d.r = 8'd0;
        s2_d.g = 8'd0;
        s2_d.b = 8'd0;
      end
    endcase
  end

  // Stage 3: desaturation, white on zero saturation
  always_comb begin
    s3_d.v        = s2_q.v;
    s3_d.val_full = s2_q.val_full;
    s3_d.val_zero = s2_q.val_zero;
    if (s2_q.sat_full) begin
      s3_d.r = s2_q.r;
      s3_d.g = s2_q.g;
      s3_d.b = s2_q.b;
    end else if (s2_q.sat_zero) begin
      s3_d.r = hsvr_pkg::LvlFull;
      s3_d.g = hsvr_pkg::LvlFull;
      s3_d.b = hsvr_pkg::LvlFull;
    end else begin
      s3_d.r = hsvr_pkg::scale8(s2_q.r, s2_q.sp1) + s2_q.d;
      s3_d.g = hsvr_pkg::scale8(s2_q.g, s2_q.sp1) + s2_q.d;
      s3_d.b = hsvr_pkg::scale8(s2_q.b, s2_q.sp1) + s2_q.d;
    end
  end

  // Stage 4: brightness, black on zero value
  always_comb begin
    logic [8:0] vp1;
    vp1 = {1'b0, s3_q.v} + 9'd1;
    if (s3_q.val_full) begin
      red_d   = s3_q.r;
      green_d = s3_q.g;
      blue_d  = s3_q.b;
    end else if (s3_q.val_zero) begin
      red_d   = 8'd0;
      green_d = 8'd0;
      blue_d  = 8'd0;
    end else begin
      red_d   = hsvr_pkg::scale8(s3_q.r, vp1);
      green_d = hsvr_pkg::scale8(s3_q.g, vp1);
      blue_d  = hsvr_pkg::scale8(s3_q.b, vp1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= hsv_i.valid;
      if (en2) s2_valid_q <= s1_valid_q;
      if (en3) s3_valid_q <= s2_valid_q;
      if (en4) s4_valid_q <= s3_valid_q;
    end
  end

  // Payload: hold on stall, no reset
  always_ff @(posedge clk_i) begin
    if (en1 && hsv_i.valid) s1_q <= s1_d;
    if (en2 && s1_valid_q)  s2_q <= s2_d;
    if (en3 && s2_valid_q)  s3_q <= s3_d;
    if (en4 && s3_valid_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

`ifndef ASSERT_OFF
  // A draining output never blocks the input
  a_ready_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_o.ready |-> hsv_i.ready)
    else $error("input stalled while output drains");

  // An empty output slot means the pipe can take a pixel
  a_ready_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rgb_o.valid |-> hsv_i.ready)
    else $error("input stalled with empty output stage");

  // Zero saturation turns a pixel white before the value stage
  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && en3 && s2_q.sat_zero) |=>
      (s3_q.r == hsvr_pkg::LvlFull && s3_q.g == hsvr_pkg::LvlFull &&
       s3_q.b == hsvr_pkg::LvlFull))
    else $error("zero saturation did not give white");

  // Zero value gives a black output beat
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && en4 && s3_q.val_zero) |=>
      (rgb_o.valid && rgb_o.red == 8'd0 && rgb_o.green == 8'd0 &&
       rgb_o.blue == 8'd0))
    else $error("zero value did not give black");
`endif

endmodule
